// ===== rtl/core/wjsp_pkg.sv =====
package wjsp_pkg;

    localparam int HEIGHT_W       = 32;
    localparam int COST_W         = 48;
    localparam int CFG_W          = 5;
    localparam int GAP_W          = 32;
    localparam int DEF_MAX_WINDOW = 16;
    localparam int DEF_MAX_LAYERS = 65536;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef enum logic [1:0] {
        ST_FETCH,
        ST_PRIME,
        ST_SCAN,
        ST_COMMIT
    } step_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_MORE,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  load_tap;
        logic  accum;
        logic  commit;
        cond_t cond;
        step_t jump_to;
        step_t fall_to;
    } ctrl_word_t;

    // microprogram: one control word per step
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t cw;
        cw = '{take_in: 1'b0, load_tap: 1'b0, accum: 1'b0, commit: 1'b0,
               cond: COND_ALWAYS, jump_to: ST_FETCH, fall_to: ST_FETCH};
        unique case (step)
            ST_FETCH:
            begin
                cw.take_in = 1'b1;
                cw.cond    = COND_IN_VALID;
                cw.jump_to = ST_PRIME;
                cw.fall_to = ST_FETCH;
            end
            ST_PRIME:
            begin
                cw.load_tap = 1'b1;
                cw.cond     = COND_ALWAYS;
                cw.jump_to  = ST_SCAN;
                cw.fall_to  = ST_SCAN;
            end
            ST_SCAN:
            begin
                cw.load_tap = 1'b1;
                cw.accum    = 1'b1;
                cw.cond     = COND_MORE;
                cw.jump_to  = ST_SCAN;
                cw.fall_to  = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cw.commit  = 1'b1;
                cw.cond    = COND_OUT_FREE;
                cw.jump_to = ST_FETCH;
                cw.fall_to = ST_COMMIT;
            end
            default:
            begin
                cw.cond = COND_ALWAYS;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/core/windowed_jump_shortest_path.sv =====
// Cheapest path over a run of layers: each input beat carries one layer height and each
// output beat the cheapest cost to reach that layer from the first layer of the run, where a
// jump of d layers (d up to the effective window) costs the height gap plus d squared and
// costs saturate at 2^48 - 1. A small microprogram steps one compare-add unit over the
// predecessors one per cycle: an input beat is followed by a prime step, the scan steps
// and a commit step that registers the result, and only then is the next beat taken;
// the next layer is taken while a finished result still waits on the output, and a
// second finished result waits in the commit step until the output frees. A window of
// 0 acts as 1, one above MAX_WINDOW as MAX_WINDOW; last_layer ends the run and the next
// beat starts again at cost 0.
module windowed_jump_shortest_path #(
    parameter int MAX_WINDOW = wjsp_pkg::DEF_MAX_WINDOW,
    parameter int MAX_LAYERS = wjsp_pkg::DEF_MAX_LAYERS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [wjsp_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [wjsp_pkg::HEIGHT_W-1:0] layer_height,
    input  logic                          last_layer,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [wjsp_pkg::COST_W-1:0]   best_cost,
    output logic                          is_last
);
    import wjsp_pkg::*;

    localparam int D_W   = $clog2(MAX_WINDOW + 2);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LYR_W = $clog2(MAX_LAYERS + 1);
    localparam int DSQ_W = 2 * D_W;
    localparam int SUM_W = COST_W + 2;

    step_t      step_reg, step_next;
    ctrl_word_t cw;
    logic       cond_true;
    logic       out_free;

    logic [CFG_W-1:0]  jump_window_reg;
    logic [LYR_W-1:0]  layer_index_reg;
    logic              out_valid_reg;

    logic [HEIGHT_W-1:0] height_ring_reg [MAX_WINDOW];
    logic [COST_W-1:0]   cost_ring_reg   [MAX_WINDOW];

    logic [HEIGHT_W-1:0] height_reg;
    logic                last_reg;
    logic [D_W-1:0]      avail_reg;
    logic [D_W-1:0]      d_reg;
    logic [GAP_W-1:0]    gap_reg;
    logic [DSQ_W-1:0]    dsq_reg;
    logic [COST_W-1:0]   cost_tap_reg;
    logic                tap_valid_reg;
    logic [COST_W-1:0]   best_reg;
    logic [COST_W-1:0]   best_cost_reg;
    logic                is_last_reg;

    logic [D_W-1:0]      win_eff;
    logic [D_W-1:0]      avail_new;
    logic [IDX_W-1:0]    tap_idx;
    logic [HEIGHT_W-1:0] tap_height;
    logic [HEIGHT_W:0]   diff_ab;
    logic [HEIGHT_W:0]   diff_ba;
    logic [GAP_W-1:0]    gap_new;
    logic [SUM_W-1:0]    sum;
    logic [COST_W-1:0]   cand;

    // effective window and predecessors available for the incoming layer
    always_comb
    begin
        if (jump_window_reg == '0)
            win_eff = D_W'(1);
        else if (32'(jump_window_reg) > 32'(MAX_WINDOW))
            win_eff = D_W'(MAX_WINDOW);
        else
            win_eff = D_W'(jump_window_reg);

        if (32'(layer_index_reg) < 32'(win_eff))
            avail_new = D_W'(layer_index_reg);
        else
            avail_new = win_eff;
    end

    // tap d sits at ring entry d - 1
    assign tap_idx    = IDX_W'(d_reg - D_W'(1));
    assign tap_height = height_ring_reg[tap_idx];
    assign diff_ab    = {tap_height[HEIGHT_W-1], tap_height}
                      - {height_reg[HEIGHT_W-1], height_reg};
    assign diff_ba    = {height_reg[HEIGHT_W-1], height_reg}
                      - {tap_height[HEIGHT_W-1], tap_height};
    assign gap_new    = diff_ab[HEIGHT_W] ? diff_ba[GAP_W-1:0] : diff_ab[GAP_W-1:0];

    always_comb
    begin
        sum = {2'b00, cost_tap_reg} + SUM_W'(gap_reg) + SUM_W'(dsq_reg);
        if (sum > SUM_W'(COST_MAX))
            cand = COST_MAX;
        else
            cand = sum[COST_W-1:0];
    end

    assign out_free = !out_valid_reg || !out_stall;

    // sequencer
    always_comb
    begin
        cw = ucode_rom(step_reg);
        unique case (cw.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_IN_VALID: cond_true = in_valid;
            COND_MORE:     cond_true = (d_reg <= avail_reg);
            COND_OUT_FREE: cond_true = out_free;
            default:       cond_true = 1'b0;
        endcase
        step_next = cond_true ? cw.jump_to : cw.fall_to;
        in_stall  = !cw.take_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= ST_FETCH;
            jump_window_reg <= CFG_W'(1);
            layer_index_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_write)
                jump_window_reg <= cfg_data;
            if (cw.commit && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                    layer_index_reg <= '0;
                else if (32'(layer_index_reg) < MAX_LAYERS)
                    layer_index_reg <= layer_index_reg + LYR_W'(1);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (cw.take_in && in_valid)
        begin
            height_reg <= layer_height;
            last_reg   <= last_layer;
            avail_reg  <= avail_new;
            d_reg      <= D_W'(1);
            best_reg   <= (layer_index_reg == '0) ? '0 : COST_MAX;
        end
        if (cw.load_tap)
        begin
            gap_reg       <= gap_new;
            dsq_reg       <= DSQ_W'(d_reg) * DSQ_W'(d_reg);
            cost_tap_reg  <= cost_ring_reg[tap_idx];
            tap_valid_reg <= (d_reg <= avail_reg);
            d_reg         <= d_reg + D_W'(1);
        end
        if (cw.accum && tap_valid_reg && (cand < best_reg))
            best_reg <= cand;
        if (cw.commit && out_free)
        begin
            for (int k = MAX_WINDOW - 1; k > 0; k--)
            begin
                height_ring_reg[k] <= height_ring_reg[k-1];
                cost_ring_reg[k]   <= cost_ring_reg[k-1];
            end
            height_ring_reg[0] <= height_reg;
            cost_ring_reg[0]   <= best_reg;
            best_cost_reg      <= best_reg;
            is_last_reg        <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign best_cost = best_cost_reg;
    assign is_last   = is_last_reg;

endmodule

// ===== tb/windowed_jump_shortest_path_test.sv =====
`timescale 1ns / 100ps

module windowed_jump_shortest_path_test;
    import wjsp_pkg::*;

    localparam int RING_DEPTH    = DEF_MAX_WINDOW;
    localparam int LAYER_CAP     = DEF_MAX_LAYERS;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_LAYERS = 820;
    localparam int LONG_RUN      = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int SHOWN_ERRORS  = 10;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = {1'b1, {(HEIGHT_W-1){1'b0}}};
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {1'b0, {(HEIGHT_W-1){1'b1}}};
    localparam logic [CFG_W-1:0]    WINDOW_TOP = {CFG_W{1'b1}};

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              last;
    } layer_result_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_write    = 1'b0;
    logic [CFG_W-1:0]    cfg_data     = '0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [HEIGHT_W-1:0] layer_height = '0;
    logic                last_layer   = 1'b0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [COST_W-1:0]   best_cost;
    logic                is_last;

    // predictor state
    longint            ring_height [RING_DEPTH];
    logic [COST_W-1:0] ring_cost [RING_DEPTH];
    int                run_layer;
    int                deepest_layer;
    logic [CFG_W-1:0]  window_reg;
    layer_result_t     pending_costs [$];

    bit                   idle_on       = 1'b1;
    int                   hold_off_left = 0;
    int                   error_count   = 0;
    int                   layers_sent   = 0;
    int                   results_seen  = 0;
    int                   ceiling_hits  = 0;
    logic [2**CFG_W-1:0]  windows_used  = '0;

    windowed_jump_shortest_path #(
        .MAX_WINDOW(RING_DEPTH),
        .MAX_LAYERS(LAYER_CAP)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .layer_height(layer_height),
        .last_layer(last_layer),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .best_cost(best_cost),
        .is_last(is_last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic predict_layer(input logic [HEIGHT_W-1:0] height, input logic last);
        int          win;
        int          avail;
        int          d;
        int          k;
        longint      h;
        logic [63:0] best;
        logic [63:0] trial;
        logic [63:0] gap;
        win = window_reg;
        if (win < 1)
            win = 1;
        if (win > RING_DEPTH)
            win = RING_DEPTH;
        avail = (run_layer < win) ? run_layer : win;
        h = longint'(signed'(height));
        best = (run_layer == 0) ? 64'd0 : 64'(COST_MAX);
        for (d = 1; d <= avail; d++)
        begin
            gap = (ring_height[d-1] > h) ? 64'(ring_height[d-1] - h)
                                         : 64'(h - ring_height[d-1]);
            trial = 64'(ring_cost[d-1]) + gap + 64'(d * d);
            if (trial > 64'(COST_MAX))
                trial = 64'(COST_MAX);
            if (trial < best)
                best = trial;
        end
        for (k = RING_DEPTH - 1; k > 0; k--)
        begin
            ring_height[k] = ring_height[k-1];
            ring_cost[k]   = ring_cost[k-1];
        end
        ring_height[0] = h;
        ring_cost[0]   = best[COST_W-1:0];
        if (best == 64'(COST_MAX))
            ceiling_hits++;
        if (last)
            run_layer = 0;
        else if (run_layer < LAYER_CAP)
            run_layer++;
        if (run_layer > deepest_layer)
            deepest_layer = run_layer;
        pending_costs.push_back('{cost: best[COST_W-1:0], last: last});
    endtask

    task automatic set_window(input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        window_reg = value;
        windows_used[value] = 1'b1;
    endtask

    // valid only drops when a gap is drawn, so back-to-back beats keep it high
    task automatic send_layer(input logic [HEIGHT_W-1:0] height, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(14, 0) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        layer_height <= height;
        last_layer   <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_layer(height, last);
        layers_sent++;
    endtask

    task automatic end_phase();
        in_valid <= 1'b0;
        while (pending_costs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [HEIGHT_W-1:0] pick_height(input int mode);
        case (mode)
            0: return HEIGHT_W'($urandom);
            1: return HEIGHT_W'($urandom_range(100, 0) - 50);
            2: return $urandom_range(1, 0) ? HEIGHT_MAX : HEIGHT_MIN;
            default: return ($urandom_range(1, 0) ? HEIGHT_MAX : HEIGHT_MIN)
                            ^ HEIGHT_W'($urandom_range(255, 0));
        endcase
    endfunction

    // reset window of one: a three-layer run, then a run that ends on its first layer
    task automatic test_reset_window();
        send_layer('0, 1'b0);
        send_layer(HEIGHT_MAX, 1'b0);
        send_layer(HEIGHT_MIN, 1'b1);
        send_layer('1, 1'b1);
        end_phase();
    endtask

    // zero window acts as one; an over-wide window clamps to the ring depth
    task automatic test_window_limits();
        int i;
        set_window('0);
        send_layer(HEIGHT_W'(5), 1'b0);
        send_layer(HEIGHT_W'(-7), 1'b0);
        send_layer(HEIGHT_W'(2), 1'b1);
        end_phase();
        set_window(WINDOW_TOP);
        for (i = 0; i <= RING_DEPTH; i++)
        begin
            if (i % 4 == 0)
                send_layer(HEIGHT_MAX, i == RING_DEPTH);
            else if (i % 4 == 2)
                send_layer(HEIGHT_MIN, i == RING_DEPTH);
            else
                send_layer(pick_height(1), i == RING_DEPTH);
        end
        end_phase();
    endtask

    // output held off while beats keep coming, then a full drain before more
    task automatic test_backpressure();
        int i;
        set_window(CFG_W'(RING_DEPTH));
        idle_on = 1'b0;
        hold_off_left = HOLD_CYCLES;
        for (i = 0; i < 40; i++)
            send_layer(HEIGHT_W'($urandom), i == 39);
        end_phase();
        for (i = 0; i < 10; i++)
            send_layer(pick_height(3), i == 9);
        end_phase();
        idle_on = 1'b1;
    endtask

    // alternating extreme heights add 2^32 per layer, so the cost grows into
    // the upper bits of the cost field over one long run
    task automatic test_long_run();
        int i;
        set_window(CFG_W'(1));
        idle_on = 1'b0;
        for (i = 0; i < LONG_RUN; i++)
            send_layer((i % 2 == 0) ? HEIGHT_MIN : HEIGHT_MAX, i == LONG_RUN - 1);
        end_phase();
        idle_on = 1'b1;
    endtask

    task automatic test_random_runs();
        int sent;
        int runs;
        int run_len;
        int mode;
        int r;
        int i;
        bit leave_open;
        sent = 0;
        while (sent < RANDOM_LAYERS)
        begin
            case ($urandom_range(5, 0))
                0: set_window('0);
                1: set_window(WINDOW_TOP);
                2: set_window(CFG_W'(RING_DEPTH));
                3: set_window(CFG_W'(1));
                default: set_window(CFG_W'($urandom_range(2**CFG_W - 1, 0)));
            endcase
            idle_on = ($urandom_range(3, 0) != 0);
            runs = $urandom_range(3, 1);
            // sometimes the run carries on into the next window setting
            leave_open = ($urandom_range(5, 0) == 0);
            for (r = 0; r < runs; r++)
            begin
                run_len = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 40)
                                                      : $urandom_range(24, 1);
                mode = $urandom_range(3, 0);
                for (i = 0; i < run_len; i++)
                    send_layer(pick_height(mode),
                               (i == run_len - 1) && !(leave_open && r == runs - 1));
                sent += run_len;
            end
            end_phase();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin : result_checker
        int            stall_left;
        layer_result_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_costs.size() == 0)
                begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS)
                        $display("unexpected result beat: cost %0d last %0b",
                                 best_cost, is_last);
                end
                else
                begin
                    want = pending_costs.pop_front();
                    if (best_cost !== want.cost || is_last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= SHOWN_ERRORS)
                            $display("result %0d: cost exp %0d got %0d, last exp %0b got %0b",
                                     results_seen, want.cost, best_cost, want.last, is_last);
                    end
                end
                stall_left = idle_on ? $urandom_range(14, 0) : 0;
            end
            if (hold_off_left > 0)
            begin
                out_stall <= 1'b1;
                hold_off_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("no beat for %0d cycles, %0d results pending", quiet, pending_costs.size());
        $display("windowed_jump_shortest_path: mismatch");
        $finish;
    end

    initial
    begin
        int i;
        for (i = 0; i < RING_DEPTH; i++)
        begin
            ring_height[i] = 0;
            ring_cost[i]   = '0;
        end
        run_layer     = 0;
        deepest_layer = 0;
        window_reg    = CFG_W'(1);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_window_limits();
        test_backpressure();
        test_long_run();
        test_random_runs();

        repeat (30) @(posedge clk);
        error_count += pending_costs.size();
        $display("%0d layers sent, %0d results checked, %0d at the cost ceiling",
                 layers_sent, results_seen, ceiling_hits);
        $display("%0d window settings used, deepest layer index %0d",
                 $countones(windows_used), deepest_layer);
        if (error_count == 0)
            $display("windowed_jump_shortest_path: match");
        else
            $display("windowed_jump_shortest_path: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/wjsp_pkg.sv
rtl/core/windowed_jump_shortest_path.sv
tb/windowed_jump_shortest_path_test.sv
